>>> rtl/fwsk_pkg.sv
package fwsk_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 18;

    // body command
    typedef struct packed {
        logic signed [31:0] linear_speed;
        logic signed [31:0] yaw_rate;
    } fwsk_cmd_t;

    // wheel set-points
    typedef struct packed {
        logic signed [31:0] angle_slot0;
        logic signed [31:0] angle_slot1;
        logic signed [31:0] angle_slot2;
        logic signed [31:0] angle_slot3;
        logic signed [31:0] speed_slot0;
        logic signed [31:0] speed_slot1;
        logic signed [31:0] speed_slot2;
        logic signed [31:0] speed_slot3;
    } fwsk_res_t;

    // register file contents
    typedef struct packed {
        logic [23:0] wheel_base;
        logic [23:0] wheel_separation;
        logic [23:0] steer_pivot_offset;
        logic [23:0] inv_wheel_radius;
    } fwsk_cfg_t;

    // register addresses (word index)
    localparam logic [1:0] REG_WHEEL_BASE = 2'd0;
    localparam logic [1:0] REG_WHEEL_SEP  = 2'd1;
    localparam logic [1:0] REG_PIVOT_OFS  = 2'd2;
    localparam logic [1:0] REG_INV_RADIUS = 2'd3;

    localparam logic [23:0] RST_WHEEL_BASE = 24'd85197;
    localparam logic [23:0] RST_WHEEL_SEP  = 24'd65536;
    localparam logic [23:0] RST_PIVOT_OFS  = 24'd0;
    localparam logic [23:0] RST_INV_RADIUS = 24'd262144;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [35:0] MAG_CAP     = 36'h4_0000_0000;

    // operands handed from front end to back end
    typedef struct packed {
        logic signed [63:0] num;
        logic signed [63:0] d_plus;
        logic signed [63:0] d_minus;
        logic        [35:0] offs_mag;
        logic signed [1:0]  sv;
        logic signed [1:0]  sw;
    } fwsk_job_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd843314857;
            5'd1:  r = 32'd497837829;
            5'd2:  r = 32'd263043837;
            5'd3:  r = 32'd133525159;
            5'd4:  r = 32'd67021687;
            5'd5:  r = 32'd33543516;
            5'd6:  r = 32'd16775851;
            5'd7:  r = 32'd8388437;
            5'd8:  r = 32'd4194283;
            5'd9:  r = 32'd2097149;
            default: r = 32'd1 << (5'd30 - i);
        endcase
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

>>> rtl/fwsk_front.sv
module fwsk_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  fwsk_pkg::fwsk_cmd_t cmd,
    input  fwsk_pkg::fwsk_cfg_t cfg,
    input  logic               q_ready,
    output logic               busy,
    output logic               q_valid,
    output fwsk_pkg::fwsk_job_t job
);
    import fwsk_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_OFS, F_DONE} fstate_t;

    fstate_t            state_reg;
    logic signed [31:0] v_reg, w_reg;
    logic signed [63:0] num_reg, wt_reg;
    logic        [63:0] p1_reg;
    fwsk_job_t          job_reg;

    logic signed [25:0] track;
    logic        [47:0] q1;
    logic        [71:0] qp;
    logic        [71:0] qs;
    logic signed [63:0] d0;

    assign track = $signed({2'b0, cfg.wheel_separation})
                 - $signed({1'b0, cfg.steer_pivot_offset, 1'b0});
    assign d0    = 64'(v_reg) <<< (FRAC_BITS + 1);
    assign q1    = 48'((p1_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    assign qp    = 72'(q1) * 72'(cfg.inv_wheel_radius);
    // saturate at 2^34 in Q16 then rescale
    assign qs    = (qp > (72'(MAG_CAP) << FRAC_BITS)) ? (72'(MAG_CAP) << FRAC_BITS) : qp;

    assign busy    = (state_reg != F_IDLE);
    assign q_valid = (state_reg == F_DONE);
    assign job     = job_reg;

    // sequencer: one multiply stage per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        v_reg     <= cmd.linear_speed;
                        w_reg     <= cmd.yaw_rate;
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    num_reg   <= 64'(w_reg) * $signed({1'b0, cfg.wheel_base});
                    wt_reg    <= 64'(w_reg) * 64'(track);
                    p1_reg    <= mag64(64'(w_reg)) * 64'(cfg.steer_pivot_offset);
                    state_reg <= F_OFS;
                end
                F_OFS:
                begin
                    job_reg.num      <= num_reg;
                    job_reg.d_plus   <= d0 + wt_reg;
                    job_reg.d_minus  <= d0 - wt_reg;
                    job_reg.offs_mag <= 36'((qs + (72'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
                    job_reg.sv       <= (v_reg == 0) ? 2'sd0 : (v_reg[31] ? -2'sd1 : 2'sd1);
                    job_reg.sw       <= (w_reg == 0) ? 2'sd0 : (w_reg[31] ? -2'sd1 : 2'sd1);
                    state_reg        <= F_DONE;
                end
                F_DONE:
                begin
                    if (q_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    a_busy_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_IDLE && in_valid) |=> busy)
        else $error("front did not take command");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_ready) |=> q_valid)
        else $error("job dropped");
    a_mul_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_MUL) |=> (state_reg == F_OFS))
        else $error("sequencer skipped");

endmodule

>>> rtl/fwsk_back.sv
module fwsk_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  fwsk_pkg::fwsk_job_t job,
    input  logic [23:0]         inv_wheel_radius,
    output logic                q_ready,
    output logic                done,
    output fwsk_pkg::fwsk_res_t res
);
    import fwsk_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_NORM, B_CORD, B_ANG, B_HSH, B_SQ, B_SQRT, B_MUL, B_SCL, B_NEXT, B_OUT
    } bstate_t;

    bstate_t            state_reg;
    fwsk_job_t          job_reg;
    logic               pass_reg;   // 0: plus side (A0, right), 1: minus side (A1, left)
    logic        [63:0] un_reg, ud_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [35:0] acc_reg;
    logic        [4:0]  it_reg;
    logic        [5:0]  s_reg;
    logic        [63:0] ua_reg, ub_reg;
    logic        [63:0] rad_reg, root_reg, bit_reg;
    logic        [87:0] prod_reg;
    logic signed [31:0] ang_reg [2];
    logic signed [36:0] spd_reg [2];
    logic               zero_reg;
    logic               out_reg;
    fwsk_res_t          res_reg;

    logic        [63:0] den_mag, mx;
    logic               ang_neg;
    logic        [31:0] zq;
    logic signed [31:0] qang;
    logic signed [33:0] ysh, xsh;
    logic        [35:0] pcap;
    logic signed [7:0]  kk;
    logic signed [37:0] lsum, rsum;
    logic signed [36:0] offs;
    logic        [61:0] sq_a, sq_b;

    assign den_mag = pass_reg ? mag64(job_reg.d_minus) : mag64(job_reg.d_plus);
    assign ang_neg = job_reg.num[63] != (pass_reg ? job_reg.d_minus[63] : job_reg.d_plus[63]);
    assign mx      = (un_reg > ud_reg) ? un_reg : ud_reg;
    assign ysh     = y_reg >>> it_reg;
    assign xsh     = x_reg >>> it_reg;
    assign zq      = acc_reg[35] ? 32'd0
                   : (acc_reg > 36'(HALF_PI_Q30)) ? HALF_PI_Q30 : acc_reg[31:0];
    assign qang    = 32'((zq + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    assign kk      = 8'(2 * FRAC_BITS + 1) - 8'(s_reg);
    assign pcap    = (prod_reg > 88'(MAG_CAP)) ? MAG_CAP : prod_reg[35:0];
    assign offs    = job_reg.sw[1] ? -$signed({1'b0, job_reg.offs_mag})
                   : (job_reg.sw == 0) ? 37'sd0 : $signed({1'b0, job_reg.offs_mag});
    assign lsum    = 38'(spd_reg[1]) - 38'(offs);
    assign rsum    = 38'(spd_reg[0]) + 38'(offs);
    // operands are below 2^31 once the hypot shift is done
    assign sq_a    = ua_reg[30:0] * ua_reg[30:0];
    assign sq_b    = ub_reg[30:0] * ub_reg[30:0];

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647)
        begin
            return 32'h7fff_ffff;
        end
        if (v < -38'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    assign q_ready = (state_reg == B_IDLE);
    assign done    = out_reg;
    assign res     = res_reg;

    // atan then hypot for each side, CORDIC and restoring sqrt one step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            out_reg   <= 1'b0;
        end
        else
        begin
            out_reg <= (state_reg == B_OUT);
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        job_reg   <= job;
                        pass_reg  <= 1'b0;
                        state_reg <= B_ANG;
                        it_reg    <= 5'd0;
                    end
                end
                B_ANG:
                begin
                    // set up atan for this side
                    un_reg   <= mag64(job_reg.num);
                    ud_reg   <= den_mag;
                    zero_reg <= (job_reg.num == 0);
                    if (job_reg.num == 0 || den_mag == 0)
                    begin
                        acc_reg   <= 36'(HALF_PI_Q30);
                        state_reg <= B_CORD;
                        it_reg    <= 5'(CORDIC_STEPS);
                    end
                    else
                    begin
                        acc_reg   <= 36'sd0;
                        state_reg <= B_NORM;
                    end
                end
                B_NORM:
                begin
                    if (mx >= 64'h4000_0000)
                    begin
                        un_reg <= un_reg >> 1;
                        ud_reg <= ud_reg >> 1;
                    end
                    else if (mx < 64'h2000_0000)
                    begin
                        un_reg <= un_reg << 1;
                        ud_reg <= ud_reg << 1;
                    end
                    else
                    begin
                        x_reg     <= 34'(ud_reg);
                        y_reg     <= 34'(un_reg);
                        it_reg    <= 5'd0;
                        state_reg <= B_CORD;
                    end
                end
                B_CORD:
                begin
                    if (it_reg == 5'(CORDIC_STEPS))
                    begin
                        ang_reg[pass_reg] <= zero_reg ? 32'sd0 : (ang_neg ? -qang : qang);
                        ua_reg    <= den_mag;
                        ub_reg    <= mag64(job_reg.num);
                        s_reg     <= 6'd0;
                        state_reg <= B_HSH;
                    end
                    else
                    begin
                        if (y_reg > 0)
                        begin
                            x_reg   <= x_reg + ysh;
                            y_reg   <= y_reg - xsh;
                            acc_reg <= acc_reg + 36'(atan_q30(it_reg));
                        end
                        else
                        begin
                            x_reg   <= x_reg - ysh;
                            y_reg   <= y_reg + xsh;
                            acc_reg <= acc_reg - 36'(atan_q30(it_reg));
                        end
                        it_reg <= it_reg + 5'd1;
                    end
                end
                B_HSH:
                begin
                    if (((ua_reg > ub_reg) ? ua_reg : ub_reg) >= 64'h8000_0000)
                    begin
                        ua_reg <= ua_reg >> 1;
                        ub_reg <= ub_reg >> 1;
                        s_reg  <= s_reg + 6'd1;
                    end
                    else
                    begin
                        state_reg <= B_SQ;
                    end
                end
                B_SQ:
                begin
                    rad_reg   <= 64'(sq_a) + 64'(sq_b);
                    root_reg  <= 64'd0;
                    bit_reg   <= 64'd1 << 62;
                    state_reg <= B_SQRT;
                end
                B_SQRT:
                begin
                    if (bit_reg == 0)
                    begin
                        state_reg <= B_MUL;
                    end
                    else
                    begin
                        if (rad_reg >= root_reg + bit_reg)
                        begin
                            rad_reg  <= rad_reg - (root_reg + bit_reg);
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                B_MUL:
                begin
                    prod_reg  <= 88'(root_reg[31:0]) * 88'(inv_wheel_radius);
                    state_reg <= B_SCL;
                end
                B_SCL:
                begin
                    if (kk > 0)
                    begin
                        prod_reg <= (prod_reg + (88'd1 << (kk - 8'sd1))) >> kk;
                    end
                    else if (kk < 0)
                    begin
                        prod_reg <= (prod_reg > (88'(MAG_CAP) >> (-kk))) ? 88'(MAG_CAP)
                                  : (prod_reg << (-kk));
                    end
                    state_reg <= B_NEXT;
                end
                B_NEXT:
                begin
                    spd_reg[pass_reg] <= job_reg.sv[1] ? -$signed({1'b0, pcap})
                                       : (job_reg.sv == 0) ? 37'sd0 : $signed({1'b0, pcap});
                    if (pass_reg)
                    begin
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= B_ANG;
                    end
                end
                B_OUT:
                begin
                    res_reg.angle_slot0 <= ang_reg[0];
                    res_reg.angle_slot1 <= ang_reg[1];
                    res_reg.angle_slot2 <= -ang_reg[1];
                    res_reg.angle_slot3 <= -ang_reg[0];
                    res_reg.speed_slot0 <= sat32(lsum);
                    res_reg.speed_slot1 <= sat32(rsum);
                    res_reg.speed_slot2 <= sat32(rsum);
                    res_reg.speed_slot3 <= sat32(lsum);
                    state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("double result");
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT) |=> done)
        else $error("result not strobed");
    a_cord_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CORD) |-> (it_reg <= 5'(CORDIC_STEPS)))
        else $error("cordic overrun");

endmodule

>>> rtl/four_wheel_steer_kinematics.sv
// Four-wheel-steer inverse kinematics.
// Command channel: drive cmd with start high while busy is low; the
// transaction is taken at that edge. Result channel: done is high for one
// cycle with res valid; the receiver cannot stall, so results never wait.
// Configuration: APB, four 24-bit registers at byte 0,4,8,12 (wheel_base,
// wheel_separation, steer_pivot_offset, inv_wheel_radius); pready is tied
// high; write only while the block is idle.
// Front end: registers the command, forms the products in a multiply stage
// and the offsets in an offset stage, then holds the job until the back end
// takes it; it then takes the next command while the back end works. Back
// end: per side an atan (normalize, 18 CORDIC steps) and a hypot (shift,
// restoring square root). A command passes intake, both sides and output in
// turn, and the back end takes no new job before it is idle again; the
// sequential square root and CORDIC in the back end set the rate.
// Reset returns registers to their defaults and drops any work in flight.
module four_wheel_steer_kinematics (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  fwsk_pkg::fwsk_cmd_t cmd,
    output logic                busy,
    output logic                done,
    output fwsk_pkg::fwsk_res_t res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import fwsk_pkg::*;

    fwsk_cfg_t cfg_reg;
    fwsk_job_t job;
    logic      q_valid, q_ready;
    logic      wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wheel_base         <= RST_WHEEL_BASE;
            cfg_reg.wheel_separation   <= RST_WHEEL_SEP;
            cfg_reg.steer_pivot_offset <= RST_PIVOT_OFS;
            cfg_reg.inv_wheel_radius   <= RST_INV_RADIUS;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_WHEEL_BASE: cfg_reg.wheel_base         <= pwdata[23:0];
                REG_WHEEL_SEP:  cfg_reg.wheel_separation   <= pwdata[23:0];
                REG_PIVOT_OFS:  cfg_reg.steer_pivot_offset <= pwdata[23:0];
                REG_INV_RADIUS: cfg_reg.inv_wheel_radius   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (paddr[3:2])
            REG_WHEEL_BASE: prdata = {8'd0, cfg_reg.wheel_base};
            REG_WHEEL_SEP:  prdata = {8'd0, cfg_reg.wheel_separation};
            REG_PIVOT_OFS:  prdata = {8'd0, cfg_reg.steer_pivot_offset};
            REG_INV_RADIUS: prdata = {8'd0, cfg_reg.inv_wheel_radius};
            default:        prdata = 32'd0;
        endcase
    end

    fwsk_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .cmd(cmd), .cfg(cfg_reg),
        .q_ready(q_ready), .busy(busy), .q_valid(q_valid), .job(job)
    );

    fwsk_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .job(job),
        .inv_wheel_radius(cfg_reg.inv_wheel_radius), .q_ready(q_ready),
        .done(done), .res(res)
    );

endmodule
